>>> rtl/sampled_string_hash_macros.svh
// Assertion macros for the sampled string hash.
`ifndef SAMPLED_STRING_HASH_MACROS_SVH
`define SAMPLED_STRING_HASH_MACROS_SVH

// Implication checked every cycle out of reset.
`define SHS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("shs assertion failed");

// Next-cycle implication, also active during reset.
`define SHS_ASSERT_NXT(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("shs assertion failed");

`endif

>>> rtl/shs_pkg.sv
package shs_pkg;

  localparam int HASH_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int STEP_SHIFT = 5;
  localparam int MIX_SHL    = 5;
  localparam int MIX_SHR    = 2;

  // Job tag that travels from the front through the queue to the back
  typedef struct packed {
    logic overflow;
    logic bank;
  } job_flags_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_ISSUE  = 3'b010,
    S_UPDATE = 3'b100
  } back_state_t;

  // One hash round: h ^ ((h << 5) + (h >> 2) + b)
  function automatic logic [HASH_W-1:0] mix(input logic [HASH_W-1:0] h,
                                            input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] sum;
    sum = (h << MIX_SHL) + (h >> MIX_SHR) + {{(HASH_W-BYTE_W){1'b0}}, b};
    return h ^ sum;
  endfunction

endpackage

>>> rtl/shs_ram.sv
module shs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/shs_front.sv
module shs_front #(
  parameter int MAX_LEN = 1024,
  parameter int LEN_W   = 11,
  parameter int AW      = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_has_byte,
  input  logic                       in_last_byte,
  output logic                       wr_en,
  output logic [AW:0]                wr_addr,
  output logic [7:0]                 wr_data,
  output logic                       push,
  output logic [LEN_W-1:0]           push_len,
  output shs_pkg::job_flags_t        push_flags
);

  logic             accept;
  logic             full;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic             ovf_r, ovf_nxt;
  logic             bank_r, bank_nxt;
  logic [LEN_W-1:0] len_now;
  logic             ovf_now;

  assign accept = start && !busy;
  assign full   = (fill_r == LEN_W'(MAX_LEN));

  // Store the byte while there is room, else flag the overflow
  assign wr_en   = accept && in_has_byte && !full;
  assign wr_addr = {bank_r, fill_r[AW-1:0]};
  assign wr_data = in_data_byte;

  assign len_now = wr_en ? fill_r + LEN_W'(1) : fill_r;
  assign ovf_now = ovf_r || (accept && in_has_byte && full);

  // Hand a finished string to the back and switch banks
  assign push                = accept && in_last_byte;
  assign push_len            = len_now;
  assign push_flags.overflow = ovf_now;
  assign push_flags.bank     = bank_r;

  always_comb begin
    fill_nxt = fill_r;
    ovf_nxt  = ovf_r;
    bank_nxt = bank_r;
    if (push) begin
      fill_nxt = '0;
      ovf_nxt  = 1'b0;
      bank_nxt = !bank_r;
    end else if (accept) begin
      fill_nxt = len_now;
      ovf_nxt  = ovf_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ovf_r  <= 1'b0;
      bank_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      ovf_r  <= ovf_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

>>> rtl/shs_queue.sv
module shs_queue #(
  parameter int LEN_W = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [LEN_W-1:0]    push_len,
  input  shs_pkg::job_flags_t push_flags,
  input  logic                pop,
  output logic                head_valid,
  output logic [LEN_W-1:0]    head_len,
  output shs_pkg::job_flags_t head_flags
);

  localparam int DEPTH = 2;

  logic [LEN_W-1:0]    len_q   [DEPTH];
  shs_pkg::job_flags_t flags_q [DEPTH];
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic [1:0]          count_r, count_nxt;

  assign head_valid = (count_r != 2'd0);
  assign head_len   = len_q[rd_ptr_r];
  assign head_flags = flags_q[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry payload, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      len_q[wr_ptr_r]   <= push_len;
      flags_q[wr_ptr_r] <= push_flags;
    end
  end

endmodule

>>> rtl/shs_back.sv
module shs_back #(
  parameter int LEN_W = 11,
  parameter int AW    = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  logic [LEN_W-1:0]                   q_len,
  input  shs_pkg::job_flags_t                q_flags,
  output logic                               pop,
  output logic [AW:0]                        rd_addr,
  input  logic [shs_pkg::BYTE_W-1:0]         rd_data,
  output logic                               done,
  output logic                               out_strobe,
  output logic [shs_pkg::HASH_W-1:0]         out_hash_value,
  output logic                               out_too_long
);

  shs_pkg::back_state_t           state_r, state_nxt;
  logic [shs_pkg::HASH_W-1:0]     h_r, h_nxt;
  logic [LEN_W-1:0]               step_r, step_nxt;
  logic [LEN_W-1:0]               pos_r, pos_nxt;
  logic                           bank_r, bank_nxt;
  logic [LEN_W-1:0]               pos_m1;
  logic                           emit;
  logic [shs_pkg::HASH_W-1:0]     emit_hash;
  logic                           emit_long;
  logic                           strobe_r;
  logic [shs_pkg::HASH_W-1:0]     hash_r;
  logic                           long_r;

  assign pos_m1  = pos_r - LEN_W'(1);
  assign rd_addr = {bank_r, pos_m1[AW-1:0]};

  // Walk the string backward, one sample per read and update pair; an overflowed string skips the walk with a zero hash
  always_comb begin
    state_nxt = state_r;
    h_nxt     = h_r;
    step_nxt  = step_r;
    pos_nxt   = pos_r;
    bank_nxt  = bank_r;
    pop       = 1'b0;
    emit      = 1'b0;
    emit_hash = h_r;
    emit_long = 1'b0;
    case (state_r)
      shs_pkg::S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_flags.overflow) begin
            emit      = 1'b1;
            emit_hash = '0;
            emit_long = 1'b1;
          end else begin
            h_nxt     = shs_pkg::HASH_W'(q_len);
            step_nxt  = (q_len >> shs_pkg::STEP_SHIFT) + LEN_W'(1);
            pos_nxt   = q_len;
            bank_nxt  = q_flags.bank;
            state_nxt = shs_pkg::S_ISSUE;
          end
        end
      end
      shs_pkg::S_ISSUE: begin
        if (pos_r >= step_r) begin
          pos_nxt   = pos_r - step_r;
          state_nxt = shs_pkg::S_UPDATE;
        end else begin
          emit      = 1'b1;
          state_nxt = shs_pkg::S_IDLE;
        end
      end
      shs_pkg::S_UPDATE: begin
        h_nxt     = shs_pkg::mix(h_r, rd_data);
        state_nxt = shs_pkg::S_ISSUE;
      end
      default: begin
        state_nxt = shs_pkg::S_IDLE;
      end
    endcase
  end

  assign done = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= shs_pkg::S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= emit;
    end
  end

  // Walk registers and held result
  always_ff @(posedge clk) begin
    h_r    <= h_nxt;
    step_r <= step_nxt;
    pos_r  <= pos_nxt;
    bank_r <= bank_nxt;
    if (emit) begin
      hash_r <= emit_hash;
      long_r <= emit_long;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_hash_value = hash_r;
  assign out_too_long   = long_r;

endmodule

>>> rtl/sampled_string_hash.sv
// Channel   Handshake              Ports
// input     start & !busy          in_data_byte, in_has_byte, in_last_byte
// result    out_strobe, one cycle  out_hash_value, out_too_long
//
// Bytes load at one item per cycle, while busy is low, into one of two
// buffer banks. An end item queues the string; the hash walk then issues a
// registered RAM read and an update per sampled byte (at most 31 samples).
// busy rises while two ended strings are still unhashed (both banks held).
// Reset is synchronous; the buffer needs no clearing pass.
// The receiver cannot stall: each result shows for exactly one cycle.
module sampled_string_hash #(
  parameter int MAX_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last_byte,
  output logic        out_strobe,
  output logic [31:0] out_hash_value,
  output logic        out_too_long
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DEPTH = 2 << AW;

  logic                wr_en;
  logic [AW:0]         wr_addr;
  logic [7:0]          wr_data;
  logic [AW:0]         rd_addr;
  logic [7:0]          rd_data;
  logic                push;
  logic [LEN_W-1:0]    push_len;
  shs_pkg::job_flags_t push_flags;
  logic                head_valid;
  logic [LEN_W-1:0]    head_len;
  shs_pkg::job_flags_t head_flags;
  logic                pop;
  logic                done;
  logic [1:0]          jobs_r, jobs_nxt;

  // Count strings that hold a bank: queued or being hashed
  assign jobs_nxt = jobs_r + {1'b0, push} - {1'b0, done};
  assign busy     = (jobs_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jobs_r <= 2'd0;
    end else begin
      jobs_r <= jobs_nxt;
    end
  end

  shs_front #(.MAX_LEN(MAX_LEN), .LEN_W(LEN_W), .AW(AW)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data_byte (in_data_byte),
    .in_has_byte  (in_has_byte),
    .in_last_byte (in_last_byte),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .push         (push),
    .push_len     (push_len),
    .push_flags   (push_flags)
  );

  shs_ram #(.WIDTH(shs_pkg::BYTE_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  shs_queue #(.LEN_W(LEN_W)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_len   (push_len),
    .push_flags (push_flags),
    .pop        (pop),
    .head_valid (head_valid),
    .head_len   (head_len),
    .head_flags (head_flags)
  );

  shs_back #(.LEN_W(LEN_W), .AW(AW)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (head_valid),
    .q_len          (head_len),
    .q_flags        (head_flags),
    .pop            (pop),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .done           (done),
    .out_strobe     (out_strobe),
    .out_hash_value (out_hash_value),
    .out_too_long   (out_too_long)
  );

endmodule

>>> rtl/shs_checker.sv
`include "sampled_string_hash_macros.svh"

module shs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_last_byte,
  input logic        out_strobe,
  input logic [31:0] out_hash_value,
  input logic        out_too_long
);

  logic [2:0] pending_r, pending_nxt;
  logic       end_taken;

  // Track ended strings whose result has not been delivered
  assign end_taken   = start && !busy && in_last_byte;
  assign pending_nxt = pending_r + {2'b00, end_taken} - {2'b00, out_strobe};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 3'd0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `SHS_ASSERT_NXT(a_no_strobe_after_reset, clk, !rst_n, !out_strobe)
  `SHS_ASSERT_IMP(a_ovf_hash_zero, clk, rst_n, out_strobe && out_too_long, out_hash_value == '0)
  `SHS_ASSERT_IMP(a_strobe_has_owner, clk, rst_n, out_strobe, pending_r != 3'd0)
  `SHS_ASSERT_IMP(a_busy_only_when_full, clk, rst_n, busy, pending_r >= 3'd2)

endmodule

bind sampled_string_hash shs_checker u_shs_checker (.*);
